FILE: rtl/dwmv_pkg.sv
// Package with the types and constants of the decay weighted mean and variance core.
`default_nettype none
package dwmv_pkg;

  localparam int unsigned MaxSamplesDef = 256;
  localparam int unsigned SampleBitsDef = 16;

  localparam int unsigned WtW   = 17;
  localparam int unsigned MeanW = 24;
  localparam int unsigned VarW  = 40;
  localparam int unsigned CfgW  = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WtW-1:0]   WeightOne = 17'h10000;
  localparam logic [MeanW-1:0] MeanMax   = 24'h7FFFFF;
  localparam logic [MeanW-1:0] MeanMin   = 24'h800000;
  localparam logic [VarW-1:0]  VarMax    = 40'hFF_FFFF_FFFF;

  localparam logic [CfgIdxW-1:0] CfgDecay     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterSel = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCenterVal = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_W,
    S_MEAN_GO,
    S_MEAN_DIV,
    S_MEAN_FIN,
    S_V_RD,
    S_V_D,
    S_V_SQ,
    S_V_LO,
    S_V_HI,
    S_V_W,
    S_VAR_GO,
    S_VAR_DIV,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/dwmv_div.sv
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module dwmv_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] n_q, q_q;
  logic [DW-1:0] r_q, den_q, r_d;
  logic [DW:0]   r_sh, r_nx;
  logic          ge;

  always_comb begin
    r_sh = {r_q, n_q[NW-1]};
    ge   = r_sh >= {1'b0, den_q};
    r_nx = ge ? (r_sh - {1'b0, den_q}) : r_sh;
    r_d  = r_nx[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      den_q <= den_i;
      r_q   <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[NW-2:0], 1'b0};
      q_q <= {q_q[NW-2:0], ge};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule
`default_nettype wire

FILE: rtl/decay_weighted_mean_variance_core.sv
// Top level of the decay weighted mean and variance core.
// Each accepted sample passes S_IDLE, S_LD_MUL and S_LD_W; a dropped sample is handled in S_IDLE.
// After the last sample: the mean division, then S_MEAN_FIN to saturate it,
// a walk over the sample memory and shared multiplier through S_V_RD, S_V_D, S_V_SQ, S_V_LO,
// S_V_HI and S_V_W per stored sample, then the variance division and S_OUT to the output register.
// Reset is asynchronous and active low; the sample memory is not cleared.
`default_nettype none
module decay_weighted_mean_variance_core #(
  parameter int unsigned MAX_SAMPLES = dwmv_pkg::MaxSamplesDef,
  parameter int unsigned SAMPLE_BITS = dwmv_pkg::SampleBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [dwmv_pkg::MeanW-1:0]        mean_o,
  output logic [dwmv_pkg::VarW-1:0]         variance_o,
  output logic                              overflow_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [dwmv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [dwmv_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int unsigned WtW    = dwmv_pkg::WtW;
  localparam int unsigned MeanW  = dwmv_pkg::MeanW;
  localparam int unsigned VarW   = dwmv_pkg::VarW;
  localparam int unsigned IDX_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned WSUM_W = WtW + CNT_W;
  localparam int unsigned WS_W   = WtW + SAMPLE_BITS + CNT_W + 1;
  localparam int unsigned D_W    = (((SAMPLE_BITS + 8) > MeanW) ? (SAMPLE_BITS + 8) : MeanW) + 1;
  localparam int unsigned AD_W   = D_W - 1;
  localparam int unsigned ACC_W  = 2 * AD_W + WtW + CNT_W;
  localparam int unsigned DEN_W  = WSUM_W + 8;

  dwmv_pkg::state_e state_q, state_d;

  logic [WtW-1:0]         decay_q, decay_d, bdec_q, bdec_d, w_q, w_d;
  logic                   csel_q, csel_d;
  logic [MeanW-1:0]       cval_q, cval_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, k_q, k_d;
  logic [WSUM_W-1:0]      wsum_q, wsum_d;
  logic [WS_W-1:0]        wss_q, wss_d;
  logic                   drop_q, drop_d;
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic                   last_q, last_d;
  logic [MeanW-1:0]       c_q, c_d, mean_q, mean_d;
  logic [AD_W-1:0]        ad_q, ad_d;
  logic [2*AD_W-1:0]      sq_q, sq_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic                   ov_q, ov_d;
  logic [MeanW-1:0]       om_q, om_d;
  logic [VarW-1:0]        ovar_q, ovar_d;
  logic                   oflow_q, oflow_d;

  logic [SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rd_q;
  logic                   mem_we;

  logic [AD_W-1:0]        mul_a, mul_b;
  logic [2*AD_W-1:0]      prod;

  logic                   div_start, div_done;
  logic [ACC_W-1:0]       div_num, div_q;
  logic [DEN_W-1:0]       div_den;

  logic                   accept;
  logic [SAMPLE_BITS-1:0] xmag;
  logic [WS_W-1:0]        pw, mag;
  logic signed [D_W-1:0]  dsv;
  logic [MeanW-1:0]       mean_c;

  assign prod = mul_a * mul_b;

  dwmv_div #(.NW(ACC_W), .DW(DEN_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[IDX_W-1:0]] <= sample_i;
    end
    rd_q <= mem_q[k_q[IDX_W-1:0]];
  end

  always_comb begin
    accept     = in_valid_i && (state_q == dwmv_pkg::S_IDLE);
    in_stall_o = state_q != dwmv_pkg::S_IDLE;
    xmag       = x_q[SAMPLE_BITS-1] ? (~x_q + 1'b1) : x_q;
    pw         = WS_W'(prod);
    mag        = wss_q[WS_W-1] ? (~wss_q + 1'b1) : wss_q;
    dsv        = (D_W'($signed(rd_q)) <<< 8) - D_W'($signed(c_q));
    if (wss_q[WS_W-1]) begin
      mean_c = (div_q > ACC_W'(dwmv_pkg::MeanMin)) ? dwmv_pkg::MeanMin
                                                    : (~div_q[MeanW-1:0] + 1'b1);
    end else begin
      mean_c = (div_q > ACC_W'(dwmv_pkg::MeanMax)) ? dwmv_pkg::MeanMax : div_q[MeanW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    decay_d  = decay_q;
    csel_d   = csel_q;
    cval_d   = cval_q;
    bdec_d   = bdec_q;
    w_d      = w_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    wsum_d   = wsum_q;
    wss_d    = wss_q;
    drop_d   = drop_q;
    x_d      = x_q;
    last_d   = last_q;
    c_d      = c_q;
    mean_d   = mean_q;
    ad_d     = ad_q;
    sq_d     = sq_q;
    acc_d    = acc_q;
    ov_d     = ov_q && out_stall_i;
    om_d     = om_q;
    ovar_d   = ovar_q;
    oflow_d  = oflow_q;
    mem_we   = 1'b0;
    mul_a    = AD_W'(w_q);
    mul_b    = AD_W'(bdec_q);
    div_start = 1'b0;
    div_num  = ACC_W'({mag, 8'b0}) + ACC_W'(wsum_q >> 1);
    div_den  = DEN_W'(wsum_q);

    if (cfg_we_i) begin
      case (cfg_index_i)
        dwmv_pkg::CfgDecay:     decay_d = cfg_data_i[WtW-1:0];
        dwmv_pkg::CfgCenterSel: csel_d  = cfg_data_i[0];
        dwmv_pkg::CfgCenterVal: cval_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      dwmv_pkg::S_IDLE: begin
        if (accept) begin
          if (cnt_q == '0) begin
            bdec_d = (decay_q > dwmv_pkg::WeightOne) ? dwmv_pkg::WeightOne : decay_q;
          end
          last_d = last_i;
          if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
            mem_we  = 1'b1;
            x_d     = sample_i;
            wsum_d  = wsum_q + WSUM_W'(w_q);
            cnt_d   = cnt_q + 1'b1;
            state_d = dwmv_pkg::S_LD_MUL;
          end else begin
            drop_d = 1'b1;
            if (last_i) begin
              state_d = dwmv_pkg::S_MEAN_GO;
            end
          end
        end
      end
      dwmv_pkg::S_LD_MUL: begin
        mul_a   = AD_W'(w_q);
        mul_b   = AD_W'(xmag);
        wss_d   = x_q[SAMPLE_BITS-1] ? (wss_q - pw) : (wss_q + pw);
        state_d = dwmv_pkg::S_LD_W;
      end
      dwmv_pkg::S_LD_W: begin
        w_d     = prod[16+WtW-1:16];
        state_d = last_q ? dwmv_pkg::S_MEAN_GO : dwmv_pkg::S_IDLE;
      end
      dwmv_pkg::S_MEAN_GO: begin
        div_start = 1'b1;
        state_d   = dwmv_pkg::S_MEAN_DIV;
      end
      dwmv_pkg::S_MEAN_DIV: begin
        if (div_done) begin
          state_d = dwmv_pkg::S_MEAN_FIN;
        end
      end
      dwmv_pkg::S_MEAN_FIN: begin
        mean_d  = mean_c;
        c_d     = csel_q ? cval_q : mean_c;
        w_d     = dwmv_pkg::WeightOne;
        k_d     = '0;
        acc_d   = ACC_W'({wsum_q, 7'b0});
        state_d = dwmv_pkg::S_V_RD;
      end
      dwmv_pkg::S_V_RD: begin
        state_d = dwmv_pkg::S_V_D;
      end
      dwmv_pkg::S_V_D: begin
        ad_d    = dsv[D_W-1] ? AD_W'(-dsv) : AD_W'(dsv);
        state_d = dwmv_pkg::S_V_SQ;
      end
      dwmv_pkg::S_V_SQ: begin
        mul_a   = ad_q;
        mul_b   = ad_q;
        sq_d    = prod;
        state_d = dwmv_pkg::S_V_LO;
      end
      dwmv_pkg::S_V_LO: begin
        mul_a   = sq_q[AD_W-1:0];
        mul_b   = AD_W'(w_q);
        acc_d   = acc_q + ACC_W'(prod);
        state_d = dwmv_pkg::S_V_HI;
      end
      dwmv_pkg::S_V_HI: begin
        mul_a   = sq_q[2*AD_W-1:AD_W];
        mul_b   = AD_W'(w_q);
        acc_d   = acc_q + (ACC_W'(prod) << AD_W);
        state_d = dwmv_pkg::S_V_W;
      end
      dwmv_pkg::S_V_W: begin
        w_d     = prod[16+WtW-1:16];
        k_d     = k_q + 1'b1;
        state_d = (CNT_W'(k_q + 1'b1) == cnt_q) ? dwmv_pkg::S_VAR_GO : dwmv_pkg::S_V_RD;
      end
      dwmv_pkg::S_VAR_GO: begin
        div_start = 1'b1;
        div_num   = acc_q;
        div_den   = {wsum_q, 8'b0};
        state_d   = dwmv_pkg::S_VAR_DIV;
      end
      dwmv_pkg::S_VAR_DIV: begin
        if (div_done) begin
          state_d = dwmv_pkg::S_OUT;
        end
      end
      dwmv_pkg::S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          om_d    = mean_q;
          ovar_d  = (div_q > ACC_W'(dwmv_pkg::VarMax)) ? dwmv_pkg::VarMax : div_q[VarW-1:0];
          oflow_d = drop_q;
          cnt_d   = '0;
          w_d     = dwmv_pkg::WeightOne;
          wsum_d  = '0;
          wss_d   = '0;
          drop_d  = 1'b0;
          bdec_d  = dwmv_pkg::WeightOne;
          state_d = dwmv_pkg::S_IDLE;
        end
      end
      default: state_d = dwmv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dwmv_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= dwmv_pkg::WeightOne;
      csel_q  <= 1'b0;
      cval_q  <= '0;
      bdec_q  <= dwmv_pkg::WeightOne;
      w_q     <= dwmv_pkg::WeightOne;
      cnt_q   <= '0;
      k_q     <= '0;
      wsum_q  <= '0;
      wss_q   <= '0;
      drop_q  <= 1'b0;
      last_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      decay_q <= decay_d;
      csel_q  <= csel_d;
      cval_q  <= cval_d;
      bdec_q  <= bdec_d;
      w_q     <= w_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      wsum_q  <= wsum_d;
      wss_q   <= wss_d;
      drop_q  <= drop_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    c_q     <= c_d;
    mean_q  <= mean_d;
    ad_q    <= ad_d;
    sq_q    <= sq_d;
    acc_q   <= acc_d;
    om_q    <= om_d;
    ovar_q  <= ovar_d;
    oflow_q <= oflow_d;
  end

  assign out_valid_o = ov_q;
  assign mean_o      = om_q;
  assign variance_o  = ovar_q;
  assign overflow_o  = oflow_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dwmv_pkg::S_V_RD) |-> (k_q < cnt_q))
    else $error("variance walk beyond stored samples");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == dwmv_pkg::S_MEAN_DIV || state_q == dwmv_pkg::S_VAR_DIV))
    else $error("divider finished outside a division state");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dwmv_pkg::S_OUT && ov_q && out_stall_i) |=> (state_q == dwmv_pkg::S_OUT))
    else $error("result overwritten while the previous request is stalled");
`endif

endmodule
`default_nettype wire

FILE: tb/dwmv_checker.sv
// Checker that predicts and compares the results of the decay weighted mean and variance core.
module dwmv_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [15:0]                  sample_i,
  input  logic                         last_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [dwmv_pkg::MeanW-1:0]   mean_i,
  input  logic [dwmv_pkg::VarW-1:0]    variance_i,
  input  logic                         overflow_i,
  input  logic                         cfg_we_i,
  input  logic [dwmv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dwmv_pkg::CfgW-1:0]    cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dwmv_pkg::*;

  localparam int unsigned Depth = 256;

  typedef struct packed {
    logic [MeanW-1:0] mean;
    logic [VarW-1:0]  variance;
    logic             overflow;
  } stats_t;

  stats_t             stats_q[$];
  logic [WtW-1:0]     decay_reg;
  logic               centre_sel_reg;
  logic [CfgW-1:0]    centre_val_reg;
  logic signed [15:0] store [Depth];
  int unsigned        count;
  logic [WtW-1:0]     weight;
  logic [WtW-1:0]     blk_decay;
  longint unsigned    weight_sum;
  longint             wsample_sum;
  logic               dropped;

  assign pending_o = stats_q.size();

  function automatic logic [WtW-1:0] next_weight(logic [WtW-1:0] w, logic [WtW-1:0] d);
    logic [33:0] p;
    p = w * d;
    return p[32:16];
  endfunction

  function automatic stats_t block_stats();
    stats_t          r;
    longint unsigned mag;
    longint unsigned q;
    longint          mean;
    longint          centre;
    longint          dev;
    logic [127:0]    ad;
    logic [127:0]    acc;
    logic [127:0]    div;
    logic [127:0]    quo;
    logic [WtW-1:0]  w;
    mag = (wsample_sum < 0) ? longint'(-wsample_sum) : longint'(wsample_sum);
    q = (mag * 256 + weight_sum / 2) / weight_sum;
    mean = (wsample_sum < 0) ? -longint'(q) : longint'(q);
    if (mean > 64'sd8388607) mean = 64'sd8388607;
    if (mean < -64'sd8388608) mean = -64'sd8388608;
    centre = centre_sel_reg ? longint'(signed'(centre_val_reg)) : mean;
    acc = '0;
    w = WeightOne;
    for (int k = 0; k < count; k++) begin
      dev = longint'(store[k]) * 256 - centre;
      ad = (dev < 0) ? 128'(-dev) : 128'(dev);
      acc = acc + ad * ad * 128'(w);
      w = next_weight(w, blk_decay);
    end
    div = 128'(weight_sum) * 256;
    acc = acc + div / 2;
    quo = acc / div;
    r.mean = mean[MeanW-1:0];
    r.variance = (quo > 128'(VarMax)) ? VarMax : quo[VarW-1:0];
    r.overflow = dropped;
    return r;
  endfunction

  task automatic clear_block();
    count = 0;
    weight = WeightOne;
    weight_sum = 0;
    wsample_sum = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t exp_r;
    if (!rst_ni) begin
      stats_q.delete();
      fail_count_o <= 0;
      decay_reg = WeightOne;
      centre_sel_reg = 1'b0;
      centre_val_reg = '0;
      blk_decay = WeightOne;
      clear_block();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (stats_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) begin
            $display("result with nothing expected: mean %h variance %h overflow %b",
                     mean_i, variance_i, overflow_i);
          end
        end else begin
          exp_r = stats_q.pop_front();
          if (exp_r.mean !== mean_i || exp_r.variance !== variance_i ||
              exp_r.overflow !== overflow_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("mismatch: mean %h/%h variance %h/%h overflow %b/%b (expected/actual)",
                       exp_r.mean, mean_i, exp_r.variance, variance_i,
                       exp_r.overflow, overflow_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (count == 0) begin
          blk_decay = (decay_reg > WeightOne) ? WeightOne : decay_reg;
        end
        if (count < Depth) begin
          store[count] = signed'(sample_i);
          weight_sum += weight;
          wsample_sum += longint'(weight) * longint'(signed'(sample_i));
          count++;
          weight = next_weight(weight, blk_decay);
        end else begin
          dropped = 1'b1;
        end
        if (last_i) begin
          stats_q.push_back(block_stats());
          clear_block();
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDecay: begin
            decay_reg = cfg_data_i[WtW-1:0];
          end
          CfgCenterSel: begin
            centre_sel_reg = cfg_data_i[0];
          end
          CfgCenterVal: begin
            centre_val_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end
endmodule

FILE: tb/tb_decay_weighted_mean_variance_core.sv
// Top of the testbench: stimulus, configuration phases and verdict for the core.
module tb_decay_weighted_mean_variance_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dwmv_pkg::*;

  localparam int IdleLimit = 40000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        sample;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic [MeanW-1:0]   mean;
  logic [VarW-1:0]    variance;
  logic               overflow;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;
  int                 fail_count;
  int                 pending;
  logic               quiet;
  int                 idle_cycles;
  int                 out_run;
  int                 blocks_sent;
  int                 long_blocks;
  int                 samples_sent;

  decay_weighted_mean_variance_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_i(sample), .last_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .mean_o(mean), .variance_o(variance), .overflow_o(overflow),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  dwmv_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .sample_i(sample), .last_i(last),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .mean_i(mean), .variance_i(variance), .overflow_i(overflow),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      out_run <= 0;
    end else if (out_run > 0) begin
      out_run <= out_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      out_run <= $urandom_range(0, 9);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [15:0] s, input logic l);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= l;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    samples_sent++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [WtW-1:0] decay, input logic sel,
                           input logic [CfgW-1:0] centre);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write(CfgDecay, CfgW'(decay));
    cfg_write(CfgCenterSel, CfgW'(sel));
    cfg_write(CfgCenterVal, centre);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(signed'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_block(input int len);
    for (int i = 1; i <= len; i++) send_sample(rand_sample(), i == len);
    blocks_sent++;
    if (len > 256) long_blocks++;
  endtask

  task automatic send_list(input logic [15:0] vals[$]);
    foreach (vals[i]) send_sample(vals[i], i == vals.size() - 1);
    blocks_sent++;
  endtask

  initial begin
    int phase_items;
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    sample = '0;
    last = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    idle_cycles = 0;
    out_run = 0;
    blocks_sent = 0;
    long_blocks = 0;
    samples_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_list('{16'h7FFF});
    send_list('{16'h8000});
    send_list('{16'h0000, 16'h7FFF, 16'h8000, 16'h0001});
    configure(17'd0, 1'b1, 24'h7FFFFF);
    send_list('{16'h8000, 16'h0005});
    configure(17'h1FFFF, 1'b0, 24'h000000);
    send_list('{16'h0064, 16'hFF9C, 16'h7FFF});
    configure(17'h10000, 1'b1, 24'h800000);
    send_list('{16'h7FFF, 16'h7FFF, 16'h7FFF});
    send_list('{16'h8000, 16'h8000});
    configure(17'h08000, 1'b0, 24'h123456);
    send_list('{16'h1234, 16'hEDCC, 16'h0000, 16'h4000, 16'hC000});

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: configure(17'h10000, 1'b0, 24'($urandom()));
        1: configure(17'd0, 1'b1, 24'($urandom()));
        2: configure(17'h1FFFF, 1'b1, 24'h7FFFFF);
        3: configure(17'h0FFFF, 1'b1, 24'h800000);
        default: configure(17'($urandom_range(0, 17'h1FFFF)), 1'($urandom()),
                           24'($urandom()));
      endcase
      quiet = (p == 8);
      phase_items = 0;
      while (phase_items < 150) begin
        if ($urandom_range(0, 29) == 0) len = $urandom_range(250, 262);
        else len = $urandom_range(1, 16);
        send_block(len);
        phase_items += len;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d samples in %0d blocks, %0d of them past the store capacity.",
             samples_sent, blocks_sent, long_blocks);
    $display("Decay, centre selection and centre value were swept over their extremes.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
